>>> rtl/pebq_pkg.sv
// Shared types, constants and helpers for the priority evicting bounded queue.
// Used by the minimum scan unit and the top level.
package pebq_pkg;

  localparam int DEPTH    = 1024;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW     = $clog2(DEPTH + 1);
  localparam int SUMW     = CNTW + 1;
  localparam int CAPW     = 11;
  localparam int PRIO_W   = 8;
  localparam int TS_W     = 64;
  localparam int ENTRY_W  = PRIO_W + TS_W;
  localparam int EVICT_W  = 11;
  localparam int COUNT_W  = 11;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  localparam int S_TDATA_W = 80;
  localparam int S_PAD_W   = S_TDATA_W - (PRIO_W + TS_W + 1);
  localparam int M_TDATA_W = 104;
  localparam int M_PAD_W   = M_TDATA_W - (3 + PRIO_W + TS_W + EVICT_W + COUNT_W);

  localparam logic [CAPW-1:0]   CAP_RESET    = CAPW'(1000);
  localparam logic [CFG_AW-1:0] REG_CAPACITY = CFG_AW'(0);

  typedef enum logic [1:0] {
    FN_ENQUEUE = 2'd0,
    FN_TAKE    = 2'd1,
    FN_RETURN  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BAD_TS      = 3'd2,
    ST_EMPTY_MSG   = 3'd3,
    ST_QUEUE_EMPTY = 3'd4,
    ST_DROPPED     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_SCAN,
    S_SCAN_WAIT,
    S_CHOOSE,
    S_COMPACT,
    S_APPEND,
    S_POP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic [AW-1:0]            idx;
    logic signed [PRIO_W-1:0] prio;
  } scan_in_t;

  // Physical slot of a logical position, the ring starting at base.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CNTW-1:0] offs);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(offs);
    if (sum >= SUMW'(DEPTH)) sum = sum - SUMW'(DEPTH);
    return AW'(sum);
  endfunction

endpackage

>>> rtl/pebq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the queue entries; no dependencies.
module pebq_ram #(
  parameter int WIDTH   = 8,
  parameter int DEPTH_P = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pebq_min_scan.sv
// Shared compare unit: tracks the lowest priority seen and its first position.
// Fed one entry per cycle by the sequencer; depends on pebq_pkg.
module pebq_min_scan import pebq_pkg::*; (
  input  logic                     clk,
  input  scan_in_t                 scan_in,
  output logic signed [PRIO_W-1:0] min_prio,
  output logic [AW-1:0]            min_idx
);

  // Strict less-than keeps the oldest entry among equal lowest priorities.
  always_ff @(posedge clk) begin
    if (scan_in.valid && (scan_in.first || (scan_in.prio < min_prio))) begin
      min_prio <= scan_in.prio;
      min_idx  <= scan_in.idx;
    end
  end

endmodule

>>> rtl/priority_evicting_bounded_queue.sv
// Bounded arrival-order queue of (priority, timestamp) entries with eviction of the
// oldest lowest-priority entry when full. Entries live in a ring inside one RAM with
// one read and one write port; every step goes through that RAM. Take-oldest passes
// through dispatch and pop, return-to-head through dispatch only, and an enqueue into a
// non-full queue through dispatch, check and append, each before the reply is handed to
// the output register. An enqueue into a full queue reads every held entry once to find
// the minimum, makes the admission decision and the checks, then closes the gap by moving
// each later entry down one slot, and repeats scan and move for each further eviction
// when the capacity was lowered. A reply that is still waiting at the output holds the
// block in its done state until taken.
// The RAM is not cleared after reset; the block is ready as soon as reset is released.
module priority_evicting_bounded_queue import pebq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // priority_req, timestamp, message_empty
  input  logic [1:0]            s_axis_tuser,  // func
  // stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, entry_priority, entry_timestamp, evicted_count, count_after
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic                  m_axis_tuser,  // entry_valid
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready
);

  state_t                   state, state_next;
  logic [AW-1:0]            head, head_next;
  logic [CNTW-1:0]          held, held_next;
  logic [CAPW-1:0]          cap;
  logic [CNTW-1:0]          eff_cap;

  func_t                    func_r, func_r_next;
  logic signed [PRIO_W-1:0] prio_r, prio_r_next;
  logic [TS_W-1:0]          ts_r, ts_r_next;
  logic                     msg_r, msg_r_next;

  status_t                  res_status, res_status_next;
  logic                     res_valid, res_valid_next;
  logic [PRIO_W-1:0]        res_prio, res_prio_next;
  logic [TS_W-1:0]          res_ts, res_ts_next;
  logic [CNTW-1:0]          evicted, evicted_next;
  logic                     evicting, evicting_next;

  logic [CNTW-1:0]          scan_j, scan_j_next;
  logic                     scan_pend, scan_pend_next;
  logic [AW-1:0]            scan_pend_idx, scan_pend_idx_next;
  logic [CNTW-1:0]          cp_rd, cp_rd_next;
  logic                     wr_pend, wr_pend_next;
  logic [CNTW-1:0]          wr_idx, wr_idx_next;

  logic                     out_valid, out_valid_next;
  status_t                  out_status;
  logic                     out_evalid;
  logic [PRIO_W-1:0]        out_prio;
  logic [TS_W-1:0]          out_ts;
  logic [CNTW-1:0]          out_evicted;
  logic [CNTW-1:0]          out_count;
  logic                     out_load;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic signed [PRIO_W-1:0] rd_prio;
  scan_in_t                 scan_in;
  logic signed [PRIO_W-1:0] min_prio;
  logic [AW-1:0]            min_idx;

  logic                     s_acc;
  logic                     cfg_wr;
  logic                     ts_bad;

  localparam int EFFW = (CAPW > CNTW) ? CAPW : CNTW;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr == REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = (paddr == REG_CAPACITY) ? CFG_DW'(cap) : '0;
  assign eff_cap = (EFFW'(cap) < EFFW'(DEPTH)) ? CNTW'(cap) : CNTW'(DEPTH);
  assign ts_bad  = (ts_r == '0) || ts_r[TS_W-1];
  assign rd_prio = $signed(ram_rdata[PRIO_W-1:0]);

  assign scan_in.valid = scan_pend;
  assign scan_in.first = (scan_pend_idx == '0);
  assign scan_in.idx   = scan_pend_idx;
  assign scan_in.prio  = rd_prio;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_evalid;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, COUNT_W'(out_count), EVICT_W'(out_evicted),
                          out_ts, out_prio, out_status};

  pebq_ram #(
    .WIDTH   (ENTRY_W),
    .DEPTH_P (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pebq_min_scan u_scan (
    .clk      (clk),
    .scan_in  (scan_in),
    .min_prio (min_prio),
    .min_idx  (min_idx)
  );

  always_comb begin
    state_next         = state;
    head_next          = head;
    held_next          = held;
    func_r_next        = func_r;
    prio_r_next        = prio_r;
    ts_r_next          = ts_r;
    msg_r_next         = msg_r;
    res_status_next    = res_status;
    res_valid_next     = res_valid;
    res_prio_next      = res_prio;
    res_ts_next        = res_ts;
    evicted_next       = evicted;
    evicting_next      = evicting;
    scan_j_next        = scan_j;
    scan_pend_next     = 1'b0;
    scan_pend_idx_next = scan_pend_idx;
    cp_rd_next         = cp_rd;
    wr_pend_next       = 1'b0;
    wr_idx_next        = wr_idx;
    out_valid_next     = out_valid && !m_axis_tready;
    out_load           = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = head;
    ram_wdata          = {ts_r, prio_r};
    ram_raddr          = head;

    case (state)
      S_IDLE: begin
        if (s_acc) begin
          func_r_next     = func_t'(s_axis_tuser);
          prio_r_next     = $signed(s_axis_tdata[PRIO_W-1:0]);
          ts_r_next       = s_axis_tdata[PRIO_W +: TS_W];
          msg_r_next      = s_axis_tdata[PRIO_W + TS_W];
          res_status_next = ST_OK;
          res_valid_next  = 1'b0;
          res_prio_next   = '0;
          res_ts_next     = '0;
          evicted_next    = '0;
          evicting_next   = 1'b0;
          state_next      = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (func_r)
          FN_ENQUEUE: begin
            if (eff_cap == '0) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else if (held < eff_cap) begin
              state_next = S_CHECK;
            end else begin
              scan_j_next = '0;
              state_next  = S_SCAN;
            end
          end
          FN_TAKE: begin
            if (held == '0) begin
              res_status_next = ST_QUEUE_EMPTY;
              state_next      = S_DONE;
            end else begin
              ram_raddr  = head;
              state_next = S_POP;
            end
          end
          FN_RETURN: begin
            if (held < eff_cap) begin
              head_next = wrap_add(head, CNTW'(DEPTH - 1));
              ram_we    = 1'b1;
              ram_waddr = wrap_add(head, CNTW'(DEPTH - 1));
              held_next = held + 1'b1;
            end else begin
              res_status_next = ST_DROPPED;
            end
            state_next = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_CHECK: begin
        if (ts_bad) begin
          res_status_next = ST_BAD_TS;
          state_next      = S_DONE;
        end else if (msg_r) begin
          res_status_next = ST_EMPTY_MSG;
          state_next      = S_DONE;
        end else if (held >= eff_cap) begin
          cp_rd_next = CNTW'(min_idx) + 1'b1;
          state_next = S_COMPACT;
        end else begin
          state_next = S_APPEND;
        end
      end

      // Issue one read per cycle; the compare unit sees the data in the following cycle.
      S_SCAN: begin
        ram_raddr          = wrap_add(head, scan_j);
        scan_pend_next     = 1'b1;
        scan_pend_idx_next = AW'(scan_j);
        scan_j_next        = scan_j + 1'b1;
        if (scan_j == held - 1'b1) begin
          state_next = S_SCAN_WAIT;
        end
      end

      S_SCAN_WAIT: begin
        state_next = S_CHOOSE;
      end

      S_CHOOSE: begin
        if (!evicting && (min_prio > prio_r)) begin
          res_status_next = ST_FULL;
          state_next      = S_DONE;
        end else if (!evicting) begin
          evicting_next = 1'b1;
          state_next    = S_CHECK;
        end else begin
          cp_rd_next = CNTW'(min_idx) + 1'b1;
          state_next = S_COMPACT;
        end
      end

      // Move every entry after the evicted one down a slot, read and write overlapped.
      S_COMPACT: begin
        if (cp_rd < held) begin
          ram_raddr    = wrap_add(head, cp_rd);
          wr_pend_next = 1'b1;
          wr_idx_next  = cp_rd - 1'b1;
          cp_rd_next   = cp_rd + 1'b1;
        end
        if (wr_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wrap_add(head, wr_idx);
          ram_wdata = ram_rdata;
        end
        if ((cp_rd >= held) && !wr_pend) begin
          held_next    = held - 1'b1;
          evicted_next = evicted + 1'b1;
          if ((held - 1'b1) >= eff_cap) begin
            scan_j_next = '0;
            state_next  = S_SCAN;
          end else begin
            state_next = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        ram_we     = 1'b1;
        ram_waddr  = wrap_add(head, held);
        held_next  = held + 1'b1;
        state_next = S_DONE;
      end

      S_POP: begin
        res_valid_next = 1'b1;
        res_prio_next  = ram_rdata[PRIO_W-1:0];
        res_ts_next    = ram_rdata[PRIO_W +: TS_W];
        head_next      = wrap_add(head, CNTW'(1));
        held_next      = held - 1'b1;
        state_next     = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || m_axis_tready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      held      <= '0;
      cap       <= CAP_RESET;
      evicting  <= 1'b0;
      scan_pend <= 1'b0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      held      <= held_next;
      evicting  <= evicting_next;
      scan_pend <= scan_pend_next;
      wr_pend   <= wr_pend_next;
      out_valid <= out_valid_next;
      if (cfg_wr) begin
        cap <= pwdata[CAPW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r        <= func_r_next;
    prio_r        <= prio_r_next;
    ts_r          <= ts_r_next;
    msg_r         <= msg_r_next;
    res_status    <= res_status_next;
    res_valid     <= res_valid_next;
    res_prio      <= res_prio_next;
    res_ts        <= res_ts_next;
    evicted       <= evicted_next;
    scan_j        <= scan_j_next;
    scan_pend_idx <= scan_pend_idx_next;
    cp_rd         <= cp_rd_next;
    wr_idx        <= wr_idx_next;
    if (out_load) begin
      out_status  <= res_status;
      out_evalid  <= res_valid;
      out_prio    <= res_prio;
      out_ts      <= res_ts;
      out_evicted <= evicted;
      out_count   <= held;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    (held <= CNTW'(DEPTH)) && (held <= eff_cap || state != S_IDLE || held <= CNTW'(DEPTH)))
    else $error("held count beyond store depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  a_entry_only_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[2:0] == ST_OK))
    else $error("popped entry reported with a failure status");

  a_no_evict_refused: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK)) |-> (out_evicted == '0))
    else $error("refused item reports evictions");

endmodule
